@@ hw/rtl/epr_pkg.sv @@
`timescale 1ns / 1ps

package epr_pkg;

	// coordinate and coefficient widths
	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int COEF_W  = 17;
	localparam int PROD_W  = COORD_W + COEF_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int FRAC_SHIFT = 15;
	localparam int RES_W   = ACC_W - FRAC_SHIFT;

	// quarter-wave sine table
	localparam int SINE_TABLE_BITS = 10;
	localparam int TABLE_SIZE      = (1 << SINE_TABLE_BITS) + 1;
	localparam int IDX_W           = SINE_TABLE_BITS + 1;
	localparam int FRACTION_BITS   = 16;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [15:0] SINE_ONE    = 16'd32768;
	localparam logic [63:0] SeriesDiv [1:10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

	// register indexes
	typedef enum logic [1:0] {
		REG_ANGLE_X = 2'd0,
		REG_ANGLE_Y = 2'd1,
		REG_ANGLE_Z = 2'd2,
		REG_NONE    = 2'd3
	} reg_index_t;

	typedef logic [15:0] sine_lut_t [0:TABLE_SIZE-1];

	// sine and cosine of one angle
	typedef struct packed {
		logic signed [COEF_W-1:0] sin_c;
		logic signed [COEF_W-1:0] cos_c;
	} coef_t;

	// table address and sign for one angle
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             neg;
	} lookup_t;

	// taylor series evaluation per table entry, done at elaboration
	function automatic sine_lut_t build_lut();
		sine_lut_t   t;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] mag;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			x = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
			term = x;
			sum = x;
			for (int n = 1; n <= 10; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / SeriesDiv[n];
				if (n % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			mag = (sum + 64'd16384) >> 15;
			if (mag > 64'(SINE_ONE)) mag = 64'(SINE_ONE);
			t[k] = mag[15:0];
		end
		return t;
	endfunction

	localparam sine_lut_t SINE_LUT = build_lut();

	// quadrant fold of an angle into a table address
	function automatic lookup_t angle_lookup(input logic [ANGLE_W-1:0] a);
		lookup_t          r;
		logic [IDX_W-1:0] i;
		i = {1'b0, a[ANGLE_W-3 -: SINE_TABLE_BITS]};
		r.idx = a[ANGLE_W-2] ? IDX_W'(TABLE_SIZE - 1) - i : i;
		r.neg = a[ANGLE_W-1];
		return r;
	endfunction

endpackage

@@ hw/rtl/epr_rotate.sv @@
`timescale 1ns / 1ps

module epr_rotate (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  logic signed [epr_pkg::COORD_W-1:0]   in_u,
	input  logic signed [epr_pkg::COORD_W-1:0]   in_v,
	input  logic signed [epr_pkg::COORD_W-1:0]   in_w,
	input  logic                                 in_sat,
	input  epr_pkg::coef_t                       coef,
	output logic                                 out_vld,
	output logic signed [epr_pkg::COORD_W-1:0]   out_u,
	output logic signed [epr_pkg::COORD_W-1:0]   out_v,
	output logic signed [epr_pkg::COORD_W-1:0]   out_w,
	output logic                                 out_sat
);

	logic                                 vld_s1;
	logic signed [epr_pkg::PROD_W-1:0]    cu_s1, sv_s1, su_s1, cv_s1;
	logic signed [epr_pkg::COORD_W-1:0]   w_s1;
	logic                                 sat_s1;

	logic signed [epr_pkg::ACC_W-1:0]     acc_u, acc_v;
	logic signed [epr_pkg::RES_W-1:0]     res_u, res_v;
	logic                                 ovf_u, ovf_v;
	logic signed [epr_pkg::COORD_W-1:0]   clip_u, clip_v;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		cu_s1  <= in_u * coef.cos_c;
		sv_s1  <= in_v * coef.sin_c;
		su_s1  <= in_u * coef.sin_c;
		cv_s1  <= in_v * coef.cos_c;
		w_s1   <= in_w;
		sat_s1 <= in_sat;
	end

	// sum, round half up, clamp
	always_comb begin
		acc_u = {{2{cu_s1[epr_pkg::PROD_W-1]}}, cu_s1} - {{2{sv_s1[epr_pkg::PROD_W-1]}}, sv_s1}
			+ epr_pkg::ACC_W'(1 << (epr_pkg::FRAC_SHIFT - 1));
		acc_v = {{2{su_s1[epr_pkg::PROD_W-1]}}, su_s1} + {{2{cv_s1[epr_pkg::PROD_W-1]}}, cv_s1}
			+ epr_pkg::ACC_W'(1 << (epr_pkg::FRAC_SHIFT - 1));
		res_u = acc_u[epr_pkg::ACC_W-1:epr_pkg::FRAC_SHIFT];
		res_v = acc_v[epr_pkg::ACC_W-1:epr_pkg::FRAC_SHIFT];
		ovf_u = (res_u[epr_pkg::RES_W-1:epr_pkg::COORD_W-1] != '0)
			&& (res_u[epr_pkg::RES_W-1:epr_pkg::COORD_W-1] != '1);
		ovf_v = (res_v[epr_pkg::RES_W-1:epr_pkg::COORD_W-1] != '0)
			&& (res_v[epr_pkg::RES_W-1:epr_pkg::COORD_W-1] != '1);
		clip_u = ovf_u ? {res_u[epr_pkg::RES_W-1], {(epr_pkg::COORD_W-1){~res_u[epr_pkg::RES_W-1]}}}
			: res_u[epr_pkg::COORD_W-1:0];
		clip_v = ovf_v ? {res_v[epr_pkg::RES_W-1], {(epr_pkg::COORD_W-1){~res_v[epr_pkg::RES_W-1]}}}
			: res_v[epr_pkg::COORD_W-1:0];
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_u   <= clip_u;
		out_v   <= clip_v;
		out_w   <= w_s1;
		out_sat <= sat_s1 | ovf_u | ovf_v;
	end

endmodule

@@ hw/rtl/euler_point_rotation.sv @@
`timescale 1ns / 1ps

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------
// command   | in        | start, busy            | in_x, in_y, in_z
// result    | out       | done (one-cycle strobe) | out_x, out_y, out_z, saturated
// config    | in        | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// one item enters every cycle, busy stays low
// latency set by input register plus product and sum stages of three rotations
// angle writes reach the coefficients through the address registers, then the table read
// reset clears valid bits and sets all angles to zero
// results cannot be stalled; no backpressure anywhere in the pipe

module euler_point_rotation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [epr_pkg::COORD_W-1:0]   in_x,
	input  logic signed [epr_pkg::COORD_W-1:0]   in_y,
	input  logic signed [epr_pkg::COORD_W-1:0]   in_z,
	output logic                                 done,
	output logic signed [epr_pkg::COORD_W-1:0]   out_x,
	output logic signed [epr_pkg::COORD_W-1:0]   out_y,
	output logic signed [epr_pkg::COORD_W-1:0]   out_z,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [epr_pkg::ANGLE_W-1:0]          cfg_data
);

	logic                          pend_q;
	epr_pkg::reg_index_t           axis_q;
	epr_pkg::lookup_t              sin_lk_q, cos_lk_q;
	epr_pkg::coef_t                coef_x_q, coef_y_q, coef_z_q, coef_new;
	logic [15:0]                   sin_mag, cos_mag;

	logic                                vld_s0;
	logic signed [epr_pkg::COORD_W-1:0]  x_s0, y_s0, z_s0;

	logic                                vld_a, sat_a, vld_b, sat_b;
	logic signed [epr_pkg::COORD_W-1:0]  y_a, z_a, x_a, z_b, x_b, y_b;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// capture write strobe, axis and table addresses every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			axis_q <= epr_pkg::REG_NONE;
		end else begin
			pend_q <= cfg_valid && cfg_ready;
			axis_q <= epr_pkg::reg_index_t'(cfg_index);
		end
	end

	always_ff @(posedge clk) begin
		sin_lk_q <= epr_pkg::angle_lookup(cfg_data);
		cos_lk_q <= epr_pkg::angle_lookup(cfg_data + epr_pkg::ANGLE_W'(16384));
	end

	// table read and sign
	always_comb begin
		sin_mag = epr_pkg::SINE_LUT[sin_lk_q.idx];
		cos_mag = epr_pkg::SINE_LUT[cos_lk_q.idx];
		coef_new.sin_c = sin_lk_q.neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
		coef_new.cos_c = cos_lk_q.neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
	end

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= '{sin_c: '0, cos_c: epr_pkg::COEF_W'(epr_pkg::SINE_ONE)};
			coef_y_q <= '{sin_c: '0, cos_c: epr_pkg::COEF_W'(epr_pkg::SINE_ONE)};
			coef_z_q <= '{sin_c: '0, cos_c: epr_pkg::COEF_W'(epr_pkg::SINE_ONE)};
		end else if (pend_q) begin
			unique case (axis_q)
				epr_pkg::REG_ANGLE_X: coef_x_q <= coef_new;
				epr_pkg::REG_ANGLE_Y: coef_y_q <= coef_new;
				epr_pkg::REG_ANGLE_Z: coef_z_q <= coef_new;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s0 <= in_x;
		y_s0 <= in_y;
		z_s0 <= in_z;
	end

	// about x: (y, z)
	epr_rotate u_rot_x (
		.clk(clk), .arst_n(arst_n),
		.in_vld(vld_s0), .in_u(y_s0), .in_v(z_s0), .in_w(x_s0), .in_sat(1'b0),
		.coef(coef_x_q),
		.out_vld(vld_a), .out_u(y_a), .out_v(z_a), .out_w(x_a), .out_sat(sat_a)
	);

	// about y: (z, x)
	epr_rotate u_rot_y (
		.clk(clk), .arst_n(arst_n),
		.in_vld(vld_a), .in_u(z_a), .in_v(x_a), .in_w(y_a), .in_sat(sat_a),
		.coef(coef_y_q),
		.out_vld(vld_b), .out_u(z_b), .out_v(x_b), .out_w(y_b), .out_sat(sat_b)
	);

	// about z: (x, y)
	epr_rotate u_rot_z (
		.clk(clk), .arst_n(arst_n),
		.in_vld(vld_b), .in_u(x_b), .in_v(y_b), .in_w(z_b), .in_sat(sat_b),
		.coef(coef_z_q),
		.out_vld(done), .out_u(out_x), .out_v(out_y), .out_w(out_z), .out_sat(saturated)
	);

`ifndef ASSERT_OFF
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s0, 6))
		else $error("done without an item six cycles earlier");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s0 |-> ##6 done)
		else $error("accepted item lost in pipeline");

	a_coef_load: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && axis_q == epr_pkg::REG_ANGLE_X) |=> (coef_x_q == $past(coef_new)))
		else $error("x coefficients not loaded");

	a_no_write_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_q |=> $stable(coef_y_q))
		else $error("y coefficients changed without a write");
`endif

endmodule
